// ----- sv/baro_pressure_temp_compensation_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_DEFINES_SVH

// Same-cycle implication
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Widths, constants and types shared by the compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Port field widths
  localparam int RAW_W       = 24;
  localparam int CAL_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int TEMP_W      = 19;
  localparam int PRES_W      = 24;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - TEMP_W - PRES_W;

  // Internal datapath widths
  localparam int DT_W    = RAW_W + 1;        // dT, signed
  localparam int MUL_W   = DT_W + CAL_W + 1; // dT times a calibration word
  localparam int SQF_W   = 2 * DT_W;         // dT squared, full product
  localparam int T1_W    = 20;               // first-order temperature
  localparam int T2_W    = 17;               // dT^2 / 2^31
  localparam int AB_W    = 21;               // T1 - 2000, T1 + 1500
  localparam int SQ_W    = 36;               // squares of the above
  localparam int CORR_W  = 40;               // OFF2, SENS2
  localparam int ACC_W   = 42;               // OFF, SENS
  localparam int SPLIT_W = 21;               // SENS split for the D1 product
  localparam int PH_W    = RAW_W + 1 + (ACC_W - SPLIT_W);
  localparam int PL_W    = RAW_W + SPLIT_W;
  localparam int Q_W     = PH_W + 1;
  localparam int DIFF_W  = Q_W + 1;

  // Shift amounts (power-of-two scale factors)
  localparam int SH_TREF = 8;
  localparam int SH_T1   = 23;
  localparam int SH_T2   = 31;
  localparam int SH_OFF  = 16;
  localparam int SH_SENS = 15;
  localparam int SH_TCO  = 7;
  localparam int SH_TCS  = 8;
  localparam int SH_P    = 15;
  localparam int PF_W    = DIFF_W - SH_P;

  // Pipeline depth, register stages from input to output
  localparam int PIPE_DEPTH = 10;

  // Temperature thresholds in 0.01 degree
  localparam logic signed [AB_W-1:0] T_REF = 21'sd2000;
  localparam logic signed [AB_W-1:0] T_LOW = -21'sd1500;

  // Second-order correction factors
  localparam int OFF2_A_K  = 5;
  localparam int OFF2_B_K  = 7;
  localparam int SENS2_B_K = 11;

  // Calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CAL_SENS     = 3'd0,
    CAL_OFF      = 3'd1,
    CAL_TCS      = 3'd2,
    CAL_TCO      = 3'd3,
    CAL_TREF     = 3'd4,
    CAL_TEMPSENS = 3'd5
  } cal_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] off;
    logic [CAL_W-1:0] tcs;
    logic [CAL_W-1:0] tco;
    logic [CAL_W-1:0] tref;
    logic [CAL_W-1:0] tempsens;
  } cal_t;

  // Front end to correction stages
  typedef struct packed {
    logic [RAW_W-1:0] d1;
    logic [T1_W-1:0]  t1;
    logic [T2_W-1:0]  t2;
    logic [ACC_W-1:0] offl;
    logic [ACC_W-1:0] sensl;
  } front_t;

  // Correction stages to pressure stages
  typedef struct packed {
    logic [RAW_W-1:0]  d1;
    logic [TEMP_W-1:0] temp;
    logic [ACC_W-1:0]  off;
    logic [ACC_W-1:0]  sens;
  } corr_t;

endpackage

// ----- sv/bpc_cfg.sv -----
// ----------------------------------------------------------------------------
// bpc_cfg
// Calibration word registers, written through the plain write port.
// ----------------------------------------------------------------------------
module bpc_cfg
  import bpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CAL_W-1:0]     cfg_wdata_i,
  output cal_t                 cal_o
);

  cal_t cal_q, cal_d;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      case (cal_idx_e'(cfg_addr_i))
        CAL_SENS:     cal_d.sens     = cfg_wdata_i;
        CAL_OFF:      cal_d.off      = cfg_wdata_i;
        CAL_TCS:      cal_d.tcs      = cfg_wdata_i;
        CAL_TCO:      cal_d.tco      = cfg_wdata_i;
        CAL_TREF:     cal_d.tref     = cfg_wdata_i;
        CAL_TEMPSENS: cal_d.tempsens = cfg_wdata_i;
        default:      cal_d          = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

// ----- sv/bpc_front.sv -----
// ----------------------------------------------------------------------------
// bpc_front
// Stages 1-3: dT, the four dT products, first-order T1, OFF and SENS bases.
// ----------------------------------------------------------------------------
module bpc_front
  import bpc_pkg::*;
(
  input  logic             clk_i,
  input  logic [2:0]       en_i,
  input  cal_t             cal_i,
  input  logic [RAW_W-1:0] raw_pressure_i,
  input  logic [RAW_W-1:0] raw_temperature_i,
  output front_t           front_o
);

  // Stage 1
  logic [RAW_W-1:0]        d1_s1_q;
  logic signed [DT_W-1:0]  dt_q, dt_d;
  // Stage 2
  logic [RAW_W-1:0]        d1_s2_q;
  logic signed [MUL_W-1:0] mul_t_q, mul_t_d;
  logic signed [MUL_W-1:0] mul_tco_q, mul_tco_d;
  logic signed [MUL_W-1:0] mul_tcs_q, mul_tcs_d;
  logic signed [SQF_W-1:0] sq_full;
  logic [T2_W-1:0]         t2_s2_q, t2_d;
  // Stage 3
  logic signed [MUL_W-1:0] t_bias, t_quo;
  logic signed [MUL_W-1:0] tco_bias, tco_quo;
  logic signed [MUL_W-1:0] tcs_bias, tcs_quo;
  front_t                  fr_q, fr_d;

  // dT = D2 - C5 * 2^8
  assign dt_d = {1'b0, raw_temperature_i} - {1'b0, cal_i.tref, {SH_TREF{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_s1_q <= raw_pressure_i;
      dt_q    <= dt_d;
    end
  end

  // Products with dT; T2 taken straight from the square
  assign mul_t_d   = dt_q * $signed({1'b0, cal_i.tempsens});
  assign mul_tco_d = dt_q * $signed({1'b0, cal_i.tco});
  assign mul_tcs_d = dt_q * $signed({1'b0, cal_i.tcs});
  assign sq_full   = dt_q * dt_q;
  assign t2_d      = sq_full[SH_T2 +: T2_W];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      d1_s2_q   <= d1_s1_q;
      mul_t_q   <= mul_t_d;
      mul_tco_q <= mul_tco_d;
      mul_tcs_q <= mul_tcs_d;
      t2_s2_q   <= t2_d;
    end
  end

  // Divisions toward zero: bias negatives by 2^k - 1, then shift
  assign t_bias   = mul_t_q + (mul_t_q[MUL_W-1] ? MUL_W'((64'd1 << SH_T1) - 64'd1) : '0);
  assign t_quo    = t_bias >>> SH_T1;
  assign tco_bias = mul_tco_q +
                    (mul_tco_q[MUL_W-1] ? MUL_W'((64'd1 << SH_TCO) - 64'd1) : '0);
  assign tco_quo  = tco_bias >>> SH_TCO;
  assign tcs_bias = mul_tcs_q +
                    (mul_tcs_q[MUL_W-1] ? MUL_W'((64'd1 << SH_TCS) - 64'd1) : '0);
  assign tcs_quo  = tcs_bias >>> SH_TCS;

  always_comb begin
    fr_d.d1    = d1_s2_q;
    fr_d.t2    = t2_s2_q;
    fr_d.t1    = t_quo[T1_W-1:0] + T1_W'(T_REF);
    fr_d.offl  = {{(ACC_W-CAL_W-SH_OFF){1'b0}}, cal_i.off, {SH_OFF{1'b0}}}
                 + ACC_W'(tco_quo);
    fr_d.sensl = {{(ACC_W-CAL_W-SH_SENS){1'b0}}, cal_i.sens, {SH_SENS{1'b0}}}
                 + ACC_W'(tcs_quo);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      fr_q <= fr_d;
    end
  end

  assign front_o = fr_q;

endmodule

// ----- sv/bpc_corr.sv -----
// ----------------------------------------------------------------------------
// bpc_corr
// Stages 4-6: second-order terms, saturated temperature, final OFF and SENS.
// ----------------------------------------------------------------------------
module bpc_corr
  import bpc_pkg::*;
(
  input  logic       clk_i,
  input  logic [2:0] en_i,
  input  front_t     front_i,
  output corr_t      corr_o
);

  logic signed [AB_W-1:0]   t1x, a_v, b_v, tdiff;
  logic signed [2*AB_W-1:0] a_sq, b_sq;
  logic [T2_W-1:0]          t2_sel;
  logic [TEMP_W-1:0]        temp_d;
  logic [AB_W-TEMP_W:0]     tdiff_top;
  // Stage 4
  logic [SQ_W-1:0]   asq_q, bsq_q;
  logic              lt_ref_q, lt_low_q;
  logic [TEMP_W-1:0] temp_s4_q;
  logic [RAW_W-1:0]  d1_s4_q;
  logic [ACC_W-1:0]  offl_s4_q, sensl_s4_q;
  // Stage 5
  logic [CORR_W-1:0] off2_q, off2_d, sens2_q, sens2_d;
  logic [TEMP_W-1:0] temp_s5_q;
  logic [RAW_W-1:0]  d1_s5_q;
  logic [ACC_W-1:0]  offl_s5_q, sensl_s5_q;
  // Stage 6
  corr_t             co_q, co_d;

  // Offsets from the thresholds and their squares
  assign t1x  = $signed({front_i.t1[T1_W-1], front_i.t1});
  assign a_v  = t1x - T_REF;
  assign b_v  = t1x - T_LOW;
  assign a_sq = a_v * a_v;
  assign b_sq = b_v * b_v;

  // TEMP = T1 - T2, T2 only below 20.00 degrees, saturated to the output field
  assign t2_sel    = (t1x < T_REF) ? front_i.t2 : '0;
  assign tdiff     = t1x - $signed({{(AB_W-T2_W){1'b0}}, t2_sel});
  assign tdiff_top = tdiff[AB_W-1:TEMP_W-1];
  always_comb begin
    if ((&tdiff_top) || !(|tdiff_top)) begin
      temp_d = tdiff[TEMP_W-1:0];
    end else begin
      temp_d = tdiff[AB_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}} : {1'b0, {(TEMP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      asq_q      <= a_sq[SQ_W-1:0];
      bsq_q      <= b_sq[SQ_W-1:0];
      lt_ref_q   <= (t1x < T_REF);
      lt_low_q   <= (t1x < T_LOW);
      temp_s4_q  <= temp_d;
      d1_s4_q    <= front_i.d1;
      offl_s4_q  <= front_i.offl;
      sensl_s4_q <= front_i.sensl;
    end
  end

  // OFF2 and SENS2, below 20.00 and below -15.00 degrees
  assign off2_d =
    (lt_ref_q ? ((CORR_W'(asq_q) * CORR_W'(OFF2_A_K)) >> 1) : '0) +
    (lt_low_q ? (CORR_W'(bsq_q) * CORR_W'(OFF2_B_K)) : '0);
  assign sens2_d =
    (lt_ref_q ? ((CORR_W'(asq_q) * CORR_W'(OFF2_A_K)) >> 2) : '0) +
    (lt_low_q ? ((CORR_W'(bsq_q) * CORR_W'(SENS2_B_K)) >> 1) : '0);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      off2_q     <= off2_d;
      sens2_q    <= sens2_d;
      temp_s5_q  <= temp_s4_q;
      d1_s5_q    <= d1_s4_q;
      offl_s5_q  <= offl_s4_q;
      sensl_s5_q <= sensl_s4_q;
    end
  end

  // Final OFF and SENS
  always_comb begin
    co_d.d1   = d1_s5_q;
    co_d.temp = temp_s5_q;
    co_d.off  = offl_s5_q - {{(ACC_W-CORR_W){1'b0}}, off2_q};
    co_d.sens = sensl_s5_q - {{(ACC_W-CORR_W){1'b0}}, sens2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      co_q <= co_d;
    end
  end

  assign corr_o = co_q;

endmodule

// ----- sv/bpc_press.sv -----
// ----------------------------------------------------------------------------
// bpc_press
// Stages 7-10: D1 * SENS / 2^21 in two partial products, minus OFF, / 2^15,
// saturation of the pressure.
// ----------------------------------------------------------------------------
module bpc_press
  import bpc_pkg::*;
(
  input  logic              clk_i,
  input  logic [3:0]        en_i,
  input  corr_t             corr_i,
  output logic [TEMP_W-1:0] temperature_o,
  output logic [PRES_W-1:0] pressure_o
);

  logic [ACC_W-SPLIT_W-1:0] sens_hi;
  logic [SPLIT_W-1:0]       sens_lo;
  // Stage 7
  logic signed [PH_W-1:0] ph_q, ph_d;
  logic [PL_W-1:0]        pl_q, pl_d;
  logic                   neg_q;
  logic [ACC_W-1:0]       off_s7_q;
  logic [TEMP_W-1:0]      temp_s7_q;
  // Stage 8
  logic                   q_inc;
  logic [Q_W-1:0]         q_q, q_d;
  logic [ACC_W-1:0]       off_s8_q;
  logic [TEMP_W-1:0]      temp_s8_q;
  // Stage 9
  logic [DIFF_W-1:0]      diff_q, diff_d;
  logic [TEMP_W-1:0]      temp_s9_q;
  // Stage 10
  logic                   p_inc;
  logic [PF_W-1:0]        p_full;
  logic [PF_W-PRES_W:0]   p_top;
  logic [PRES_W-1:0]      pres_q, pres_d;
  logic [TEMP_W-1:0]      temp_q;

  // Split SENS so each product stays narrow
  assign sens_hi = corr_i.sens[ACC_W-1:SPLIT_W];
  assign sens_lo = corr_i.sens[SPLIT_W-1:0];
  assign ph_d    = $signed({1'b0, corr_i.d1}) * $signed(sens_hi);
  assign pl_d    = corr_i.d1 * sens_lo;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ph_q      <= ph_d;
      pl_q      <= pl_d;
      // product is negative exactly when SENS < 0 and D1 is nonzero
      neg_q     <= corr_i.sens[ACC_W-1] && (corr_i.d1 != '0);
      off_s7_q  <= corr_i.off;
      temp_s7_q <= corr_i.temp;
    end
  end

  // Quotient by 2^21 toward zero: floor, plus one for a negative with remainder
  assign q_inc = neg_q && (pl_q[SPLIT_W-1:0] != '0);
  assign q_d   = {ph_q[PH_W-1], ph_q}
               + {{(Q_W-PL_W+SPLIT_W){1'b0}}, pl_q[PL_W-1:SPLIT_W]}
               + {{(Q_W-1){1'b0}}, q_inc};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q_q       <= q_d;
      off_s8_q  <= off_s7_q;
      temp_s8_q <= temp_s7_q;
    end
  end

  // Subtract OFF
  assign diff_d = {q_q[Q_W-1], q_q} - {{(DIFF_W-ACC_W){off_s8_q[ACC_W-1]}}, off_s8_q};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      diff_q    <= diff_d;
      temp_s9_q <= temp_s8_q;
    end
  end

  // Divide by 2^15 toward zero, then saturate
  assign p_inc  = diff_q[DIFF_W-1] && (diff_q[SH_P-1:0] != '0);
  assign p_full = diff_q[DIFF_W-1:SH_P] + {{(PF_W-1){1'b0}}, p_inc};
  assign p_top  = p_full[PF_W-1:PRES_W-1];

  always_comb begin
    if ((&p_top) || !(|p_top)) begin
      pres_d = p_full[PRES_W-1:0];
    end else begin
      pres_d = p_full[PF_W-1] ? {1'b1, {(PRES_W-1){1'b0}}} : {1'b0, {(PRES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      pres_q <= pres_d;
      temp_q <= temp_s9_q;
    end
  end

  assign temperature_o = temp_q;
  assign pressure_o    = pres_q;

endmodule

// ----- sv/baro_pressure_temp_compensation_top.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Second-order temperature compensation of a barometric sensor reading pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one raw pressure / raw temperature pair per
//   transaction; output stream returns one temperature (0.01 degree) and one
//   pressure (0.01 mbar) per transaction, both saturated, in input order.
//   Six calibration words are written through cfg_we_i / cfg_addr_i /
//   cfg_wdata_i while no transaction is in flight; indexes 6 and 7 are ignored.
//   Pipeline: the result passes through the ten register stages (dT,
//   products, T1, squares, OFF2/SENS2, OFF/SENS, split D1*SENS products,
//   quotient, OFF subtract, final scale).
//   Throughput: one transaction per cycle, sustained while m_axis_tready
//   stays high.
//   Receiver stall: a full stage holds while its successor does not load, so
//   empty stages keep filling; s_axis_tready drops only once every stage holds
//   an item and the result is not taken.
//   Reset: all calibration words return to zero, the pipeline empties and
//   s_axis_tready stays low until the first clock after reset is released.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_top_defines.svh"

module baro_pressure_temp_compensation_top
  import bpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CAL_W-1:0]       cfg_wdata_i,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [18:0] temperature, [42:19] pressure, zero pad
);

  cal_t                  cal;
  front_t                front;
  corr_t                 corr;
  logic [TEMP_W-1:0]     temperature;
  logic [PRES_W-1:0]     pressure;
  logic [PIPE_DEPTH-1:0] valid_q, valid_d, adv;
  logic                  run_q;
  logic                  in_fire, out_fire;

  // Calibration registers
  bpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cal_o       (cal)
  );

  // Stage advance: a stage loads when it is empty or its successor loads
  always_comb begin
    adv[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || m_axis_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = run_q && adv[0];
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // Valid bits follow the data
  always_comb begin
    valid_d[0] = adv[0] ? in_fire : valid_q[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      run_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      run_q   <= 1'b1;
    end
  end

  // Datapath
  bpc_front u_front (
    .clk_i             (clk_i),
    .en_i              (adv[2:0]),
    .cal_i             (cal),
    .raw_pressure_i    (s_axis_tdata[RAW_W-1:0]),
    .raw_temperature_i (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .front_o           (front)
  );

  bpc_corr u_corr (
    .clk_i   (clk_i),
    .en_i    (adv[5:3]),
    .front_i (front),
    .corr_o  (corr)
  );

  bpc_press u_press (
    .clk_i         (clk_i),
    .en_i          (adv[9:6]),
    .corr_i        (corr),
    .temperature_o (temperature),
    .pressure_o    (pressure)
  );

  assign m_axis_tvalid = valid_q[PIPE_DEPTH-1];
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, pressure, temperature};

  // Checks
  `BPC_ASSERT_NXT(a_item_count,
    1'b1,
    $countones(valid_q) == $countones($past(valid_q)) + int'($past(in_fire))
                           - int'($past(out_fire)),
    "pipeline item count does not match accepted and delivered transactions")

  `BPC_ASSERT_IMP(a_full_stall,
    (&valid_q) && !m_axis_tready,
    !s_axis_tready,
    "input accepted while every stage is full and output is stalled")

  `BPC_ASSERT_NXT(a_cfg_sens_write,
    cfg_we_i && (cfg_addr_i == CAL_SENS),
    cal.sens == $past(cfg_wdata_i),
    "sensitivity calibration word not updated by write")

endmodule

// ----- tb/baro_comp_check.sv -----
// ----------------------------------------------------------------------------
// baro_comp_check
// Watches the calibration port and both streams of the compensation block,
// keeps its own calibration copy, predicts temperature and pressure for every
// accepted reading pair and compares each returned transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_comp_check
  import bpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CAL_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // [18:0] temperature, [42:19] pressure, zero pad
  output int                     pending_o,
  output int                     fail_count_o
);

  typedef struct packed {
    logic signed [PRES_W-1:0] pressure;
    logic signed [TEMP_W-1:0] temperature;
  } reading_t;

  // Scale factors and limits, all in 64-bit signed arithmetic
  localparam longint ROOM_TEMP  = 2000;
  localparam longint COLD_TEMP  = -1500;
  localparam longint TREF_MUL   = longint'(1) << 8;
  localparam longint T1_DIV     = longint'(1) << 23;
  localparam longint T2_DIV     = longint'(1) << 31;
  localparam longint OFF_MUL    = longint'(1) << 16;
  localparam longint SENS_MUL   = longint'(1) << 15;
  localparam longint TCO_DIV    = longint'(1) << 7;
  localparam longint TCS_DIV    = longint'(1) << 8;
  localparam longint PROD_DIV   = longint'(1) << 21;
  localparam longint P_DIV      = longint'(1) << 15;
  localparam longint TEMP_LO    = -(longint'(1) << (TEMP_W - 1));
  localparam longint TEMP_HI    = (longint'(1) << (TEMP_W - 1)) - 1;
  localparam longint PRES_LO    = -(longint'(1) << (PRES_W - 1));
  localparam longint PRES_HI    = (longint'(1) << (PRES_W - 1)) - 1;

  cal_t     cal;
  reading_t expected_readings [$];
  reading_t want;
  reading_t got;
  int       errors;

  function automatic longint widen(input logic [RAW_W-1:0] v);
    return longint'({40'd0, v});
  endfunction

  // Second-order compensation of one reading pair, divisions truncate toward zero
  function automatic reading_t compensate_reading(input logic [RAW_W-1:0] d1_raw,
                                                  input logic [RAW_W-1:0] d2_raw);
    longint d1, dt, t1, t2, off2, sens2, temp, off, sens, p, a, b;
    reading_t r;
    d1    = widen(d1_raw);
    dt    = widen(d2_raw) - widen(cal.tref) * TREF_MUL;
    t1    = ROOM_TEMP + (dt * widen(cal.tempsens)) / T1_DIV;
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (t1 < ROOM_TEMP) begin
      a     = t1 - ROOM_TEMP;
      t2    = (dt * dt) / T2_DIV;
      off2  = 5 * (a * a) / 2;
      sens2 = 5 * (a * a) / 4;
    end
    // extra term when very cold
    if (t1 < COLD_TEMP) begin
      b     = t1 - COLD_TEMP;
      off2  = off2 + 7 * (b * b);
      sens2 = sens2 + 11 * (b * b) / 2;
    end
    temp = t1 - t2;
    off  = widen(cal.off) * OFF_MUL + (widen(cal.tco) * dt) / TCO_DIV - off2;
    sens = widen(cal.sens) * SENS_MUL + (widen(cal.tcs) * dt) / TCS_DIV - sens2;
    p    = (d1 * sens / PROD_DIV - off) / P_DIV;
    // saturate to the output fields
    if (temp < TEMP_LO) temp = TEMP_LO;
    if (temp > TEMP_HI) temp = TEMP_HI;
    if (p < PRES_LO) p = PRES_LO;
    if (p > PRES_HI) p = PRES_HI;
    r.temperature = temp[TEMP_W-1:0];
    r.pressure    = p[PRES_W-1:0];
    return r;
  endfunction

  // Track calibration, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal = '0;
      expected_readings.delete();
      errors = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cal_idx_e'(cfg_addr_i))
          CAL_SENS:     cal.sens     = cfg_wdata_i;
          CAL_OFF:      cal.off      = cfg_wdata_i;
          CAL_TCS:      cal.tcs      = cfg_wdata_i;
          CAL_TCO:      cal.tco      = cfg_wdata_i;
          CAL_TREF:     cal.tref     = cfg_wdata_i;
          CAL_TEMPSENS: cal.tempsens = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_readings.push_back(compensate_reading(s_axis_tdata_i[RAW_W-1:0],
                                                       s_axis_tdata_i[2*RAW_W-1:RAW_W]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.temperature = m_axis_tdata_i[TEMP_W-1:0];
        got.pressure    = m_axis_tdata_i[TEMP_W+PRES_W-1:TEMP_W];
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected transaction: temperature %0d, pressure %0d",
                   $time, got.temperature, got.pressure);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (got.temperature !== want.temperature) begin
            $display("%0t: temperature mismatch: expected %0d, actual %0d",
                     $time, want.temperature, got.temperature);
            errors++;
          end
          if (got.pressure !== want.pressure) begin
            $display("%0t: pressure mismatch: expected %0d, actual %0d",
                     $time, want.pressure, got.pressure);
            errors++;
          end
          if (m_axis_tdata_i[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
            $display("%0t: pad bits mismatch: expected 0, actual %0h",
                     $time, m_axis_tdata_i[OUT_TDATA_W-1 -: OUT_PAD_W]);
            errors++;
          end
        end
      end
      pending_o    <= expected_readings.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ----- tb/tb_baro_pressure_temp_compensation_top.sv -----
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation_top
// Drives reading pairs and calibration sets into the compensation block with
// random idle stretches on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation_top;
  import bpc_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_READINGS = 140;
  localparam int PAUSE_AT       = 70;
  localparam int BURST_FIRST    = 90;
  localparam int BURST_LAST     = 120;
  localparam int RAW_MAX        = (1 << RAW_W) - 1;

  // indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] CAL_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CAL_IDX_SPARE_HI = 3'd7;

  localparam cal_t TYPICAL_CAL = '{sens: 16'd40127, off: 16'd36924, tcs: 16'd23317,
                                   tco: 16'd23282, tref: 16'd33464, tempsens: 16'd28312};
  localparam cal_t ALL_ONES_CAL = '1;
  localparam cal_t ALL_ZERO_CAL = '0;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i    = '0;
  logic [CAL_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int   results_pending;
  int   fail_count;
  int   idle_cycles = 0;
  bit   no_idle     = 1'b0;
  cal_t cal;

  baro_pressure_temp_compensation_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  baro_comp_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .pending_o      (results_pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no pause, some short ones, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cal_t random_cal();
    cal_t c;
    logic [CAL_W-1:0] w [6];
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 7))
        0:       w[i] = '0;
        1:       w[i] = '1;
        default: w[i] = CAL_W'($urandom_range(0, (1 << CAL_W) - 1));
      endcase
    end
    c = '{sens: w[0], off: w[1], tcs: w[2], tco: w[3], tref: w[4], tempsens: w[5]};
    return c;
  endfunction

  // Raw temperature at a signed offset from the reference point, kept in range
  function automatic logic [RAW_W-1:0] near_tref(input int offset);
    int v;
    v = int'(cal.tref) * 256 + offset;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v[RAW_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] random_temperature_raw();
    case ($urandom_range(0, 9))
      0, 1, 2: return RAW_W'($urandom_range(0, RAW_MAX));
      3, 4:    return near_tref(int'($urandom_range(0, 8192)) - 4096);
      5, 6:    return near_tref(-int'($urandom_range(0, 4000000)));
      7:       return near_tref(int'($urandom_range(0, 4000000)));
      8:       return near_tref(-int'($urandom_range(4000000, RAW_MAX)));
      default: return $urandom_range(0, 1) ? '0 : RAW_MAX[RAW_W-1:0];
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] random_pressure_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAW_MAX[RAW_W-1:0];
      default: return RAW_W'($urandom_range(0, RAW_MAX));
    endcase
  endfunction

  // One reading pair, preceded by an optional idle stretch
  task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int pause_len;
    pause_len = no_idle ? 0 : idle_len();
    if (pause_len > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause_len) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d2, d1};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Block is idle here; optionally poke an unused index first
  task automatic write_calibration(input cal_t c, input bit spare);
    cal = c;
    if (spare) begin
      write_reg($urandom_range(0, 1) ? CAL_IDX_SPARE_LO : CAL_IDX_SPARE_HI,
                CAL_W'($urandom_range(0, (1 << CAL_W) - 1)));
    end
    write_reg(CAL_SENS, c.sens);
    write_reg(CAL_OFF, c.off);
    write_reg(CAL_TCS, c.tcs);
    write_reg(CAL_TCO, c.tco);
    write_reg(CAL_TREF, c.tref);
    write_reg(CAL_TEMPSENS, c.tempsens);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: ready stretches of random length, short ones and long ones
  initial begin : receiver
    int hold;
    int stall;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles with no transaction on either stream
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int tref_offsets [12];
    logic [RAW_W-1:0] d1_picks [3];
    tref_offsets = '{0, -1, -296, -297, -298, 300, -1037000, -1037044, -1040000,
                     -3000000, -8566784, 8210431};
    d1_picks     = '{24'd6465444, 24'd0, 24'hFFFFFF};
    cal          = ALL_ZERO_CAL;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // calibration untouched since reset
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h123456, 24'hABCDEF);
    wait_for_results();

    // typical calibration, around the two temperature thresholds
    write_calibration(TYPICAL_CAL, 1'b1);
    foreach (tref_offsets[i]) send_reading(d1_picks[i % 3], near_tref(tref_offsets[i]));
    wait_for_results();

    // every word at its maximum, corner readings
    write_calibration(ALL_ONES_CAL, 1'b0);
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'd0);
    send_reading(24'd0, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    wait_for_results();

    // random phases, first at all ones and last at all zeros
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0)
        write_calibration(ALL_ONES_CAL, 1'b0);
      else if (ph == NUM_PHASES - 1)
        write_calibration(ALL_ZERO_CAL, 1'b1);
      else if (ph % 4 == 1)
        write_calibration(TYPICAL_CAL, 1'b0);
      else
        write_calibration(random_cal(), ph % 3 == 0);
      for (int k = 0; k < PHASE_READINGS; k++) begin
        if (k == PAUSE_AT) wait_for_results();
        no_idle = (k >= BURST_FIRST) && (k < BURST_LAST);
        send_reading(random_pressure_raw(), random_temperature_raw());
      end
      no_idle = 1'b0;
      wait_for_results();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
